@@ rtl/core/gtdp_pkg.sv @@
`timescale 1ns / 1ps
package gtdp_pkg;
   localparam int QW = 10;
   localparam int GW = 7;
   localparam int NDIR = 4;
   localparam logic [GW-1:0] EMPTY_GREEN_RESET = 7'd30;
   typedef logic [QW-1:0] queue_type;
   typedef logic [GW-1:0] green_type;
endpackage

@@ rtl/core/green_time_dp_allocator.sv @@
`timescale 1ns / 1ps
// A word is worked by one shared multiply-square-add-compare unit that visits S_RD, S_MUL and
// S_SQ for each (dir, t, a) step, S_WR once per t and S_CMP once per direction; traceback then
// visits S_TB and S_OUT for each direction before rsp_tvalid is set.
// Throughput: one word at a time; req_tready is low while a word is in work or its result waits.
// All-zero queues: result valid the cycle after acceptance. Result sits in an output register.
// Reset: synchronous, active high; clears control and sets empty_green_time to 30.
module green_time_dp_allocator #(
   parameter int CYCLE_TIME = 120
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // queue_north, queue_south, queue_east, queue_west
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // green_north, green_south, green_east, green_west, used_default
   output logic [31:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);
   import gtdp_pkg::*;

   localparam int TW = $clog2(CYCLE_TIME + 2);
   localparam int DEP = CYCLE_TIME + 1;
   localparam int AW = $clog2(DEP);
   localparam int CHW = $clog2(NDIR * DEP);
   localparam int CW = 64;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_SQ   = 3'd3;
   localparam logic [2:0] S_CMP  = 3'd4;
   localparam logic [2:0] S_WR   = 3'd5;
   localparam logic [2:0] S_TB   = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0] state_ff;
   logic [6:0] egt_ff;
   queue_type q_ff [NDIR];
   logic [QW+1:0] total_ff;
   logic [1:0] dir_ff;
   logic [TW-1:0] t_ff, a_ff;
   logic [CW-1:0] bank0_ff [DEP];
   logic [CW-1:0] bank1_ff [DEP];
   logic [TW-1:0] ch_mem [NDIR*DEP];
   logic [CW-1:0] pc_ff, best_ff;
   logic [23:0] d_ff;
   logic pv_ff, bv_ff;
   logic [TW-1:0] ba_ff, ch_rd_ff, tb_t_ff;
   green_type g_ff [NDIR];
   logic def_ff, rv_ff;

   logic [QW+1:0] tot_in;
   logic [TW-1:0] idx_t;
   logic [CW-1:0] cost_in;
   logic [31:0] pa, pb;
   logic [TW-1:0] tb_a;
   logic [CHW-1:0] ch_wa, ch_ra;

   assign tot_in = QW'(0) + {2'b0, req_tdata[9:0]} + {2'b0, req_tdata[19:10]}
                 + {2'b0, req_tdata[29:20]} + {2'b0, req_tdata[39:30]};
   assign idx_t = t_ff - a_ff;
   assign pa = 32'(a_ff) * 32'(total_ff);
   assign pb = 32'(q_ff[dir_ff]) * 32'(CYCLE_TIME);
   assign cost_in = pc_ff + CW'(48'(d_ff) * 48'(d_ff));
   assign tb_a = (ch_rd_ff > tb_t_ff) ? tb_t_ff : ch_rd_ff;
   assign ch_wa = CHW'(32'(dir_ff) * 32'(DEP) + 32'(t_ff));
   assign ch_ra = CHW'(32'(dir_ff) * 32'(DEP) + 32'(tb_t_ff));
   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {3'b0, def_ff, g_ff[3], g_ff[2], g_ff[1], g_ff[0]};

   // even directions write bank0, odd directions write bank1
   always_ff @(posedge clock) begin
      case (state_ff)
         S_RD: begin
            pc_ff <= (dir_ff == 2'd0) ? '0
                   : (dir_ff[0] ? bank0_ff[AW'(idx_t)] : bank1_ff[AW'(idx_t)]);
            pv_ff <= (dir_ff == 2'd0) ? (idx_t == '0) : 1'b1;
         end
         S_MUL: d_ff <= 24'((pa >= pb) ? (pa - pb) : (pb - pa));
         S_SQ: begin
            if (pv_ff && (!bv_ff || cost_in < best_ff)) begin
               best_ff <= cost_in;
               ba_ff <= a_ff;
               bv_ff <= 1'b1;
            end
         end
         S_WR: begin
            if (dir_ff[0]) bank1_ff[AW'(t_ff)] <= best_ff;
            else bank0_ff[AW'(t_ff)] <= best_ff;
            ch_mem[ch_wa] <= bv_ff ? ba_ff : '0;
            bv_ff <= 1'b0;
         end
         S_IDLE: bv_ff <= 1'b0;
         default: ;
      endcase
      if (state_ff == S_TB)
         ch_rd_ff <= ch_mem[ch_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         egt_ff <= EMPTY_GREEN_RESET;
         rv_ff <= 1'b0;
      end else begin
         if (csr_wr_en) egt_ff <= csr_wr_data;
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  for (int i = 0; i < NDIR; i++) q_ff[i] <= req_tdata[i*QW +: QW];
                  total_ff <= tot_in;
                  dir_ff <= '0; t_ff <= '0; a_ff <= '0;
                  if (tot_in == '0) begin
                     for (int i = 0; i < NDIR; i++) g_ff[i] <= egt_ff;
                     def_ff <= 1'b1;
                     rv_ff <= 1'b1;
                  end else state_ff <= S_RD;
               end
            end
            S_RD: state_ff <= S_MUL;
            S_MUL: state_ff <= S_SQ;
            S_SQ: begin
               if (a_ff == t_ff) state_ff <= S_WR;
               else begin a_ff <= a_ff + 1'b1; state_ff <= S_RD; end
            end
            S_WR: begin
               a_ff <= '0;
               if (t_ff == TW'(CYCLE_TIME)) begin
                  state_ff <= S_CMP;
               end else begin
                  t_ff <= t_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_CMP: begin
               t_ff <= '0;
               tb_t_ff <= TW'(CYCLE_TIME);
               if (dir_ff == 2'd3) state_ff <= S_TB;
               else begin dir_ff <= dir_ff + 1'b1; state_ff <= S_RD; end
            end
            S_TB: state_ff <= S_OUT;
            S_OUT: begin
               g_ff[dir_ff] <= GW'(tb_a);
               tb_t_ff <= tb_t_ff - tb_a;
               if (dir_ff == 2'd0) begin
                  def_ff <= 1'b0;
                  rv_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  dir_ff <= dir_ff - 1'b1;
                  state_ff <= S_TB;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped");
   a_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && dir_ff == 2'd0) |-> (tb_a == tb_t_ff))
      else $error("split does not cover cycle");
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import gtdp_pkg::*;

   localparam int CYC = 120;

   typedef struct {
      green_type g[NDIR];
      logic      used_default;
   } split_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;

   green_type   empty_green;
   split_type   split_q[$];
   int          errors;
   int          words_checked;
   int          settings_used;
   bit          long_hold;

   green_time_dp_allocator #(.CYCLE_TIME(CYC)) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // exact DP split of the cycle, costs scaled by total^2
   function automatic split_type predict_split(queue_type q[NDIR], green_type dflt);
      longint best [NDIR+1][CYC+1];
      bit     reach[NDIR+1][CYC+1];
      int     pick [NDIR+1][CYC+1];
      int     total;
      int     t;
      int     a;
      int     pa;
      longint d;
      longint c;
      split_type r;
      total = 0;
      for (int i = 0; i < NDIR; i++) total += q[i];
      if (total == 0) begin
         for (int i = 0; i < NDIR; i++) r.g[i] = dflt;
         r.used_default = 1'b1;
         return r;
      end
      for (int i = 0; i <= NDIR; i++)
         for (int j = 0; j <= CYC; j++) begin
            best[i][j] = 0;
            reach[i][j] = 0;
            pick[i][j] = 0;
         end
      reach[0][0] = 1;
      for (int i = 1; i <= NDIR; i++)
         for (t = 0; t <= CYC; t++)
            for (a = 0; a <= t; a++) begin
               if (!reach[i-1][t-a]) continue;
               d = longint'(a) * total - longint'(q[i-1]) * CYC;
               c = best[i-1][t-a] + d * d;
               if (!reach[i][t] || c < best[i][t]) begin
                  reach[i][t] = 1;
                  best[i][t] = c;
                  pick[i][t] = a;
               end
            end
      t = CYC;
      for (int i = NDIR; i >= 1; i--) begin
         pa = (pick[i][t] > t) ? t : pick[i][t];
         r.g[i-1] = green_type'(pa);
         t -= pa;
      end
      r.used_default = 1'b0;
      return r;
   endfunction

   task automatic send_word(input queue_type q[NDIR], input bit typed,
                            input split_type typed_res, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {q[3], q[2], q[1], q[0]};
      do @(posedge clock); while (!req_tready);
      split_q.push_back(typed ? typed_res : predict_split(q, empty_green));
   endtask

   task automatic drain_and_write(input logic [6:0] value);
      req_tvalid <= 1'b0;
      while (split_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      empty_green = value;
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 9);
      if (p < 5) return 0;
      if (p < 9) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   function automatic split_type mk_res(int gn, int gs, int ge, int gw, int ud);
      split_type r;
      r.g[0] = green_type'(gn);
      r.g[1] = green_type'(gs);
      r.g[2] = green_type'(ge);
      r.g[3] = green_type'(gw);
      r.used_default = 1'(ud);
      return r;
   endfunction

   // directed rows: queues, whether a result is typed in, and that result
   typedef struct {
      int        q[NDIR];
      bit        typed;
      split_type res;
   } row_type;
   row_type rows[$];

   task automatic add_row(int n, int s, int e, int w, bit typed, split_type res);
      row_type r;
      r.q[0] = n; r.q[1] = s; r.q[2] = e; r.q[3] = w;
      r.typed = typed;
      r.res = res;
      rows.push_back(r);
   endtask

   // stalls on the result side; one long hold on request
   initial begin
      int p;
      int run;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end else begin
            p = $urandom_range(0, 9);
            if (p < 6) begin
               rsp_tready <= 1'b1;
               run = $urandom_range(1, 20);
            end else if (p < 9) begin
               rsp_tready <= 1'b0;
               run = $urandom_range(1, 3);
            end else begin
               rsp_tready <= 1'b0;
               run = $urandom_range(20, 60);
            end
            repeat (run) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      split_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (split_q.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            e = split_q.pop_front();
            words_checked++;
            if (rsp_tdata[6:0] !== e.g[0]) begin
               $error("green_north expected %0d actual %0d", e.g[0], rsp_tdata[6:0]);
               errors++;
            end
            if (rsp_tdata[13:7] !== e.g[1]) begin
               $error("green_south expected %0d actual %0d", e.g[1], rsp_tdata[13:7]);
               errors++;
            end
            if (rsp_tdata[20:14] !== e.g[2]) begin
               $error("green_east expected %0d actual %0d", e.g[2], rsp_tdata[20:14]);
               errors++;
            end
            if (rsp_tdata[27:21] !== e.g[3]) begin
               $error("green_west expected %0d actual %0d", e.g[3], rsp_tdata[27:21]);
               errors++;
            end
            if (rsp_tdata[28] !== e.used_default) begin
               $error("used_default expected %0d actual %0d", e.used_default, rsp_tdata[28]);
               errors++;
            end
         end
      end
   end

   initial begin
      #(64'd1_000_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      queue_type q[NDIR];
      split_type none;
      int        kind;
      int        dir;
      errors = 0;
      words_checked = 0;
      settings_used = 1;
      long_hold = 0;
      empty_green = EMPTY_GREEN_RESET;
      none = mk_res(0, 0, 0, 0, 0);
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(0, 0, 0, 0, 1, mk_res(30, 30, 30, 30, 1));
      add_row(1023, 0, 0, 0, 1, mk_res(120, 0, 0, 0, 0));
      add_row(0, 1023, 0, 0, 1, mk_res(0, 120, 0, 0, 0));
      add_row(0, 0, 1, 0, 1, mk_res(0, 0, 120, 0, 0));
      add_row(0, 0, 0, 1, 1, mk_res(0, 0, 0, 120, 0));
      add_row(1023, 1023, 1023, 1023, 1, mk_res(30, 30, 30, 30, 0));
      add_row(1, 1, 1, 1, 1, mk_res(30, 30, 30, 30, 0));
      add_row(1, 1, 1, 0, 1, mk_res(40, 40, 40, 0, 0));
      add_row(3, 0, 0, 1, 1, mk_res(90, 0, 0, 30, 0));
      add_row(1, 1, 0, 0, 1, mk_res(60, 60, 0, 0, 0));
      add_row(1, 2, 3, 4, 0, none);
      add_row(1023, 1, 0, 0, 0, none);
      add_row(682, 341, 682, 341, 0, none);
      add_row(1023, 1022, 512, 511, 0, none);
      add_row(7, 0, 5, 3, 0, none);
      add_row(0, 0, 0, 0, 1, mk_res(30, 30, 30, 30, 1));
      foreach (rows[r]) begin
         for (int i = 0; i < NDIR; i++) q[i] = queue_type'(rows[r].q[i]);
         send_word(q, rows[r].typed, rows[r].res, pick_gap());
      end

      drain_and_write(7'd0);
      send_word('{default: '0}, 1, mk_res(0, 0, 0, 0, 1), 0);
      drain_and_write(7'd127);
      long_hold = 1;
      for (int k = 0; k < 6; k++) send_word('{default: '0}, 1, mk_res(127, 127, 127, 127, 1), 0);
      drain_and_write(7'd121);
      send_word('{default: '0}, 1, mk_res(121, 121, 121, 121, 1), 0);

      for (int ph = 0; ph < 4; ph++) begin
         drain_and_write(ph == 0 ? 7'd120 : 7'($urandom_range(0, 127)));
         for (int k = 0; k < 25; k++) begin
            kind = $urandom_range(0, 9);
            for (int i = 0; i < NDIR; i++) q[i] = '0;
            if (kind == 1) begin
               dir = $urandom_range(0, NDIR - 1);
               q[dir] = queue_type'($urandom);
            end else if (kind < 4 && kind != 0) begin
               for (int i = 0; i < NDIR; i++) q[i] = queue_type'($urandom_range(0, 7));
            end else if (kind < 6 && kind != 0) begin
               for (int i = 0; i < NDIR; i++)
                  q[i] = ($urandom_range(0, 1) == 1) ? queue_type'($urandom) : '0;
            end else if (kind != 0) begin
               for (int i = 0; i < NDIR; i++) q[i] = queue_type'($urandom);
            end
            send_word(q, 0, none, pick_gap());
         end
      end

      req_tvalid <= 1'b0;
      while (split_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d result words checked across %0d default-green settings,", words_checked,
               settings_used);
      $display("covering empty, single-queue, tie, small and full-range queue mixes");
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
